// ===== src/morse_keyer_tone_generator_unit_defines.svh =====
// assertion macros shared by the morse keyer rtl
// needs clk and rst_n in the scope of the module that uses them
`ifndef MORSE_KEYER_TONE_GENERATOR_UNIT_DEFINES_SVH
`define MORSE_KEYER_TONE_GENERATOR_UNIT_DEFINES_SVH

// condition and consequence in the same cycle
`define MKTG_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define MKTG_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mktg_pkg.sv =====
// shared types, codes and tables of the morse keyer tone generator
// no dependencies
package mktg_pkg;

  // op codes carried on in_tuser
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DOT_LEN    = 3'd0;
  localparam logic [2:0] CFG_DASH_LEN   = 3'd1;
  localparam logic [2:0] CFG_LETTER_GAP = 3'd2;
  localparam logic [2:0] CFG_WORD_GAP   = 3'd3;
  localparam logic [2:0] CFG_LEAD_LEN   = 3'd4;
  localparam logic [2:0] CFG_PHASE_STEP = 3'd5;

  // segment kinds
  localparam logic [2:0] SEG_IDLE   = 3'd0;
  localparam logic [2:0] SEG_LEAD   = 3'd1;
  localparam logic [2:0] SEG_WORD   = 3'd2;
  localparam logic [2:0] SEG_LETTER = 3'd3;
  localparam logic [2:0] SEG_TONE   = 3'd4;
  localparam logic [2:0] SEG_SPACE  = 3'd5;

  // bit positions of the pending gap flags
  localparam int PEND_LEAD   = 0;
  localparam int PEND_WORD   = 1;
  localparam int PEND_LETTER = 2;

  localparam int ELEM_W = 7;   // most elements in one character
  localparam int CNT_W  = 3;
  localparam int LEFT_W = 17;  // widest segment length
  localparam int MORSE_N = 47;

  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [ELEM_W-1:0] bits;   // bit 0 is the first element, 1 means dash
  } morse_ent_t;

  typedef struct packed {
    logic              known;
    logic [CNT_W-1:0]  len;
    logic [ELEM_W-1:0] bits;
  } code_t;

  typedef struct packed {
    logic [13:0] dot_len;
    logic [15:0] dash_len;
    logic [14:0] letter_gap_len;
    logic [16:0] word_gap_len;
    logic [15:0] lead_len;
    logic [14:0] phase_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dot_len:        14'd960,
    dash_len:       16'd2880,
    letter_gap_len: 15'd1920,
    word_gap_len:   17'd5760,
    lead_len:       16'd2880,
    phase_step:     15'd6144
  };

  typedef struct packed {
    logic tone_on;
    logic busy;
    logic accepted;
  } seq_res_t;

  // letters a to z, digits 0 to 9, then . , ? ! / & : ; _ $ @
  localparam morse_ent_t MORSE_TAB [MORSE_N] = '{
    {3'd2, 7'b0000010}, {3'd4, 7'b0000001}, {3'd4, 7'b0000101}, {3'd3, 7'b0000001},
    {3'd1, 7'b0000000}, {3'd4, 7'b0000100}, {3'd3, 7'b0000011}, {3'd4, 7'b0000000},
    {3'd2, 7'b0000000}, {3'd4, 7'b0001110}, {3'd3, 7'b0000101}, {3'd4, 7'b0000010},
    {3'd2, 7'b0000011}, {3'd2, 7'b0000001}, {3'd3, 7'b0000111}, {3'd4, 7'b0000110},
    {3'd4, 7'b0001011}, {3'd3, 7'b0000010}, {3'd3, 7'b0000000}, {3'd1, 7'b0000001},
    {3'd3, 7'b0000100}, {3'd4, 7'b0001000}, {3'd3, 7'b0000110}, {3'd4, 7'b0001001},
    {3'd4, 7'b0001101}, {3'd4, 7'b0000011},
    {3'd5, 7'b0011111}, {3'd5, 7'b0011110}, {3'd5, 7'b0011100}, {3'd5, 7'b0011000},
    {3'd5, 7'b0010000}, {3'd5, 7'b0000000}, {3'd5, 7'b0000001}, {3'd5, 7'b0000011},
    {3'd5, 7'b0000111}, {3'd5, 7'b0001111},
    {3'd6, 7'b0101010}, {3'd6, 7'b0110011}, {3'd6, 7'b0001100}, {3'd6, 7'b0110101},
    {3'd5, 7'b0001001}, {3'd5, 7'b0000010}, {3'd6, 7'b0000111}, {3'd6, 7'b0010101},
    {3'd6, 7'b0101100}, {3'd7, 7'b1001000}, {3'd6, 7'b0010110}
  };

  // quarter-wave amplitude, taylor series through x^11 in q30, rounded to q15
  // evaluated at elaboration only
  function automatic logic [14:0] sine_quarter(input int unsigned r,
                                               input int unsigned abits);
    longint unsigned x;
    longint unsigned t;
    longint          sum;
    longint          amp;
    x = (64'(r) * 64'd1686629713) >> (abits - 2);
    sum = longint'(x);
    t = x;
    t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd6;   sum = sum - longint'(t);
    t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd20;  sum = sum + longint'(t);
    t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd42;  sum = sum - longint'(t);
    t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd72;  sum = sum + longint'(t);
    t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd110; sum = sum - longint'(t);
    if (sum < 0) sum = 0;
    amp = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (amp > 32767) amp = 32767;
    return 15'(amp);
  endfunction

endpackage

// ===== src/morse_keyer_tone_generator_unit.sv =====
// top level of the morse keyer tone generator
// depends on mktg_pkg, mktg_char_decode, mktg_sine_rom and mktg_seg_seq
//
// usage
//   in channel: in_tuser carries the op (start message, offer character,
//   sample tick), in_tdata the ascii character; every item gives exactly one
//   out item: sample, tone_on, busy_res and accepted
//   characters are refused (accepted low) while the previous one still has
//   segments left; the sender keeps ticking and offers again later
//   cfg port: one register a cycle with cfg_we, while no item is in flight
// timing
//   one item per cycle sustained while out_tready stays high; an item taken
//   sits in the input register and its result is registered in the result
//   register once that frees up; the path between the registers is the
//   sine table lookup plus the segment search over up to seven elements
// reset and backpressure
//   synchronous, active low; config returns to its defaults, the message state
//   clears with the lead silence armed and both channels run empty
//   with out_tready low the result register holds, the input register keeps
//   one item and in_tready drops; nothing is lost or repeated
module morse_keyer_tone_generator_unit
  import mktg_pkg::*;
#(
  parameter int PHASE_BITS     = 16,
  parameter int SINE_ADDR_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] sample, [16] tone_on, [17] busy_res,
                                  // [18] accepted, [23:19] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  cfg_t        cfg_r;

  // input register
  logic        in_vld_r;
  logic [1:0]  in_op_r;
  logic [7:0]  in_char_r;

  // result register
  logic        out_vld_r;
  logic [15:0] out_sample_r;
  logic        out_tone_r;
  logic        out_busy_r;
  logic        out_acc_r;

  logic        adv;
  logic        step_en;
  code_t       code;
  logic        is_space;
  logic [PHASE_BITS-1:0] phase;
  logic signed [15:0]    rom_sample;
  seq_res_t    res;

  // result register frees up when empty or being taken
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign step_en   = in_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DOT_LEN:    cfg_r.dot_len        <= cfg_wdata[13:0];
        CFG_DASH_LEN:   cfg_r.dash_len       <= cfg_wdata[15:0];
        CFG_LETTER_GAP: cfg_r.letter_gap_len <= cfg_wdata[14:0];
        CFG_WORD_GAP:   cfg_r.word_gap_len   <= cfg_wdata;
        CFG_LEAD_LEN:   cfg_r.lead_len       <= cfg_wdata[15:0];
        CFG_PHASE_STEP: cfg_r.phase_step     <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_op_r   <= in_tuser;
      in_char_r <= in_tdata;
    end
  end

  mktg_char_decode u_decode (
    .char_code (in_char_r),
    .code      (code),
    .is_space  (is_space)
  );

  mktg_seg_seq #(
    .PHASE_BITS (PHASE_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .op       (in_op_r),
    .code     (code),
    .is_space (is_space),
    .cfg      (cfg_r),
    .phase    (phase),
    .res      (res)
  );

  // sample of the current phase, before this tick advances it
  mktg_sine_rom #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine (
    .phase  (phase),
    .sample (rom_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_sample_r <= res.tone_on ? rom_sample : 16'sd0;
      out_tone_r   <= res.tone_on;
      out_busy_r   <= res.busy;
      out_acc_r    <= res.accepted;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_acc_r, out_busy_r, out_tone_r, out_sample_r};

endmodule

// ===== src/mktg_char_decode.sv =====
// character decoder: case fold, whitespace detect and morse table lookup
// depends on mktg_pkg
module mktg_char_decode
  import mktg_pkg::*;
(
  input  logic [7:0] char_code,
  output code_t      code,
  output logic       is_space
);

  logic [7:0] up;
  logic [5:0] idx;
  logic       hit;

  always_comb begin
    up  = char_code;
    idx = '0;
    hit = 1'b0;
    if (char_code >= 8'd97 && char_code <= 8'd122) begin
      up = char_code - 8'd32;
    end
    if (up >= 8'd65 && up <= 8'd90) begin
      idx = 6'(up - 8'd65);
      hit = 1'b1;
    end else if (up >= 8'd48 && up <= 8'd57) begin
      idx = 6'(up - 8'd48) + 6'd26;
      hit = 1'b1;
    end else begin
      hit = 1'b1;
      case (up)
        8'd46:   idx = 6'd36;  // period
        8'd44:   idx = 6'd37;  // comma
        8'd63:   idx = 6'd38;  // question mark
        8'd33:   idx = 6'd39;  // exclamation
        8'd47:   idx = 6'd40;  // slash
        8'd38:   idx = 6'd41;  // ampersand
        8'd58:   idx = 6'd42;  // colon
        8'd59:   idx = 6'd43;  // semicolon
        8'd95:   idx = 6'd44;  // underscore
        8'd36:   idx = 6'd45;  // dollar
        8'd64:   idx = 6'd46;  // at sign
        default: hit = 1'b0;
      endcase
    end
  end

  assign is_space   = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
  assign code.known = hit;
  assign code.len   = hit ? MORSE_TAB[idx].len : '0;
  assign code.bits  = hit ? MORSE_TAB[idx].bits : '0;

endmodule

// ===== src/mktg_sine_rom.sv =====
// sine lookup: quarter-wave constant table with quadrant folding
// depends on mktg_pkg
module mktg_sine_rom
  import mktg_pkg::*;
#(
  parameter int PHASE_BITS     = 16,
  parameter int SINE_ADDR_BITS = 8
) (
  input  logic [PHASE_BITS-1:0] phase,
  output logic signed [15:0]    sample
);

  localparam int QSIZE = 1 << (SINE_ADDR_BITS - 2);
  localparam int QW    = SINE_ADDR_BITS - 1;

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QW-1:0]             r_eff;
  logic [14:0]               quarter_tab [QSIZE+1];
  logic [15:0]               amp16;

  for (genvar g = 0; g <= QSIZE; g++) begin : g_quarter
    assign quarter_tab[g] = sine_quarter(g, SINE_ADDR_BITS);
  end

  if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_hi
    assign addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  end else begin : g_addr_lo
    assign addr = {phase, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
  end

  assign quad  = addr[SINE_ADDR_BITS-1 -: 2];
  // odd quadrants run the table backwards
  assign r_eff = quad[0] ? (QW'(QSIZE) - {1'b0, addr[SINE_ADDR_BITS-3:0]})
                         : {1'b0, addr[SINE_ADDR_BITS-3:0]};
  assign amp16  = {1'b0, quarter_tab[r_eff]};
  assign sample = quad[1] ? (16'd0 - amp16) : amp16;

endmodule

// ===== src/mktg_seg_seq.sv =====
// segment sequencer: message state, gap and element queue, sample countdown
// depends on mktg_pkg and the assertion macro header
`include "morse_keyer_tone_generator_unit_defines.svh"

module mktg_seg_seq
  import mktg_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [1:0]            op,
  input  code_t                 code,
  input  logic                  is_space,
  input  cfg_t                  cfg,
  output logic [PHASE_BITS-1:0] phase,
  output seq_res_t              res
);

  logic [2:0]            kind_r, kind_nxt;
  logic [LEFT_W-1:0]     left_r, left_nxt;
  logic [2:0]            pend_r, pend_nxt;
  logic [ELEM_W-1:0]     bits_r, bits_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  inside_r, inside_nxt;
  logic                  seen_r, seen_nxt;
  logic                  lead_r, lead_nxt;

  // next-segment search inputs and results
  logic                  run_ns;
  logic [2:0]            ns_kind_in;
  logic [2:0]            ns_pend_in;
  logic [ELEM_W-1:0]     ns_bits_in;
  logic [CNT_W-1:0]      ns_cnt_in;
  logic [2:0]            ns_kind;
  logic [LEFT_W-1:0]     ns_left;
  logic [2:0]            ns_pend;
  logic [ELEM_W-1:0]     ns_bits;
  logic [CNT_W-1:0]      ns_cnt;
  logic                  ns_tone;
  logic [ELEM_W-1:0]     cand;
  logic                  found;
  logic [CNT_W-1:0]      first_idx;
  logic                  dot_nz;
  logic                  dash_nz;

  assign dot_nz  = (cfg.dot_len != '0);
  assign dash_nz = (cfg.dash_len != '0);

  // find the next segment of nonzero length; zero-length tones are consumed,
  // a zero-length dash still leaves its dot-length space behind
  always_comb begin
    for (int i = 0; i < ELEM_W; i++) begin
      cand[i] = (CNT_W'(i) < ns_cnt_in) && (dot_nz || (ns_bits_in[i] && dash_nz));
    end
    found     = 1'b0;
    first_idx = '0;
    for (int i = ELEM_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found     = 1'b1;
        first_idx = CNT_W'(i);
      end
    end

    ns_kind = SEG_IDLE;
    ns_left = '0;
    ns_pend = '0;
    ns_bits = '0;
    ns_cnt  = '0;
    ns_tone = 1'b0;
    if (ns_kind_in == SEG_TONE && dot_nz) begin
      ns_kind = SEG_SPACE;
      ns_left = LEFT_W'(cfg.dot_len);
      ns_pend = ns_pend_in;
      ns_bits = ns_bits_in;
      ns_cnt  = ns_cnt_in;
    end else if (ns_pend_in[PEND_LEAD] && cfg.lead_len != '0) begin
      ns_kind = SEG_LEAD;
      ns_left = LEFT_W'(cfg.lead_len);
      ns_pend = ns_pend_in & ~(3'b001 << PEND_LEAD);
      ns_bits = ns_bits_in;
      ns_cnt  = ns_cnt_in;
    end else if (ns_pend_in[PEND_WORD] && cfg.word_gap_len != '0) begin
      ns_kind = SEG_WORD;
      ns_left = cfg.word_gap_len;
      ns_pend = ns_pend_in & (3'b001 << PEND_LETTER);
      ns_bits = ns_bits_in;
      ns_cnt  = ns_cnt_in;
    end else if (ns_pend_in[PEND_LETTER] && cfg.letter_gap_len != '0) begin
      ns_kind = SEG_LETTER;
      ns_left = LEFT_W'(cfg.letter_gap_len);
      ns_bits = ns_bits_in;
      ns_cnt  = ns_cnt_in;
    end else if (found) begin
      if (ns_bits_in[first_idx] && !dash_nz) begin
        // empty dash tone, only its trailing space remains
        ns_kind = SEG_SPACE;
        ns_left = LEFT_W'(cfg.dot_len);
      end else begin
        ns_kind = SEG_TONE;
        ns_left = ns_bits_in[first_idx] ? LEFT_W'(cfg.dash_len) : LEFT_W'(cfg.dot_len);
        ns_tone = 1'b1;
      end
      ns_bits = ns_bits_in >> ({1'b0, first_idx} + 4'd1);
      ns_cnt  = ns_cnt_in - (first_idx + 3'd1);
    end
  end

  always_comb begin
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    pend_nxt   = pend_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    inside_nxt = inside_r;
    seen_nxt   = seen_r;
    lead_nxt   = lead_r;
    run_ns     = 1'b0;
    ns_kind_in = kind_r;
    ns_pend_in = pend_r;
    ns_bits_in = bits_r;
    ns_cnt_in  = cnt_r;
    res        = '0;

    if (step_en) begin
      case (op)
        OP_START: begin
          kind_nxt   = SEG_IDLE;
          left_nxt   = '0;
          pend_nxt   = '0;
          bits_nxt   = '0;
          cnt_nxt    = '0;
          phase_nxt  = '0;
          inside_nxt = 1'b0;
          seen_nxt   = 1'b0;
          lead_nxt   = 1'b1;
        end
        OP_CHAR: begin
          // a character is only taken between characters
          if (kind_r == SEG_IDLE) begin
            res.accepted = 1'b1;
            if (is_space) begin
              inside_nxt = 1'b0;
            end else begin
              ns_kind_in              = SEG_IDLE;
              ns_pend_in              = '0;
              ns_pend_in[PEND_LEAD]   = lead_r;
              ns_pend_in[PEND_LETTER] = inside_r;
              ns_pend_in[PEND_WORD]   = !inside_r && seen_r;
              ns_bits_in              = code.bits;
              ns_cnt_in               = code.len;
              lead_nxt                = 1'b0;
              inside_nxt              = 1'b1;
              seen_nxt                = 1'b1;
              run_ns                  = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (kind_r != SEG_IDLE) begin
            if (kind_r == SEG_TONE) begin
              res.tone_on = 1'b1;
              phase_nxt   = phase_r + PHASE_BITS'(cfg.phase_step);
            end
            left_nxt = left_r - LEFT_W'(1);
            if (left_r == LEFT_W'(1)) begin
              run_ns = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (run_ns) begin
      kind_nxt = ns_kind;
      left_nxt = ns_left;
      pend_nxt = ns_pend;
      bits_nxt = ns_bits;
      cnt_nxt  = ns_cnt;
      if (ns_tone) begin
        phase_nxt = '0;
      end
    end
    res.busy = (kind_nxt != SEG_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= SEG_IDLE;
      left_r   <= '0;
      pend_r   <= '0;
      bits_r   <= '0;
      cnt_r    <= '0;
      phase_r  <= '0;
      inside_r <= 1'b0;
      seen_r   <= 1'b0;
      lead_r   <= 1'b1;
    end else begin
      kind_r   <= kind_nxt;
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      bits_r   <= bits_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      inside_r <= inside_nxt;
      seen_r   <= seen_nxt;
      lead_r   <= lead_nxt;
    end
  end

  assign phase = phase_r;

  `MKTG_ASSERT_SAME(a_active_has_samples, kind_r != SEG_IDLE, left_r != '0,
    "active segment with no samples left")
  `MKTG_ASSERT_SAME(a_idle_queue_empty, kind_r == SEG_IDLE, cnt_r == '0 && pend_r == '0,
    "idle with elements or gaps still queued")
  `MKTG_ASSERT_NEXT(a_refused_char_holds,
    step_en && op == OP_CHAR && kind_r != SEG_IDLE,
    kind_r == $past(kind_r) && left_r == $past(left_r) && cnt_r == $past(cnt_r),
    "refused character changed the segment state")

endmodule

// ===== dv/mktg_tone_checker.sv =====
// result checker for the morse keyer tone generator: watches the config port and both channels
// keeps its own copy of the keyer state, predicts every result item and compares field by field
// depends on mktg_pkg for op, segment and register codes
module mktg_tone_checker
  import mktg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [15:0] sample, [16] tone_on, [17] busy_res, [18] accepted
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          tone_samples,
  output int          chars_taken
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               tone_on;
    logic               busy;
    logic               accepted;
  } keyed_out_t;

  typedef struct packed {
    logic       known;
    logic [2:0] count;
    logic [6:0] marks;   // bit 0 first, 1 is a dash
  } morse_t;

  string code_str [47] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.",
    ".-.-.-", "--..--", "..--..", "-.-.--", "-..-.", ".-...", "---...",
    "-.-.-.", "..--.-", "...-..-", ".--.-."
  };
  string punct_str = ".,?!/&:;_$@";

  logic [13:0] dot_len;
  logic [15:0] dash_len;
  logic [14:0] letter_gap;
  logic [16:0] word_gap;
  logic [15:0] lead_len;
  logic [14:0] phase_step;

  logic [6:0]  marks_left;
  logic [2:0]  marks_cnt;
  logic [2:0]  seg_kind;
  logic [16:0] seg_left;
  logic [15:0] tone_phase;
  logic        in_word;
  logic        word_seen;
  logic        lead_armed;
  logic [2:0]  gaps;

  keyed_out_t awaited_out [$];

  // quarter-wave taylor series in q30, rounded to q15, sign from the quadrant
  function automatic logic signed [15:0] sine_of(input logic [15:0] ph);
    logic [7:0]        addr;
    logic [1:0]        quad;
    int unsigned       r;
    int unsigned       k;
    longint unsigned   x;
    longint unsigned   t;
    longint            acc;
    longint            amp;
    addr = ph[15:8];
    quad = addr[7:6];
    r = addr[5:0];
    if (quad[0]) r = 64 - r;
    x = (longint'(r) * 64'd1686629713) >> 6;
    acc = longint'(x);
    t = x;
    for (k = 1; k <= 5; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / longint'((2 * k) * (2 * k + 1));
      if (k[0]) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    amp = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
    if (amp > 32767) amp = 32767;
    return quad[1] ? -16'(amp) : 16'(amp);
  endfunction

  function automatic morse_t morse_of(input logic [7:0] ch);
    morse_t m;
    int     idx;
    int     i;
    string  s;
    m = '0;
    idx = -1;
    if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
    if (ch >= "A" && ch <= "Z") idx = ch - "A";
    else if (ch >= "0" && ch <= "9") idx = ch - "0" + 26;
    else begin
      for (i = 0; i < 11; i++)
        if (ch == punct_str[i]) idx = 36 + i;
    end
    if (idx >= 0) begin
      s = code_str[idx];
      m.known = 1'b1;
      for (i = 0; i < s.len() && i < 7; i++)
        if (s[i] == "-") m.marks[i] = 1'b1;
      m.count = 3'(i);
    end
    return m;
  endfunction

  function void clear_message();
    marks_left = '0;
    marks_cnt  = '0;
    seg_kind   = SEG_IDLE;
    seg_left   = '0;
    tone_phase = '0;
    in_word    = 1'b0;
    word_seen  = 1'b0;
    lead_armed = 1'b1;
    gaps       = '0;
  endfunction

  // step to the next segment with a nonzero length, or to idle
  function void advance_segment();
    bit done;
    done = 1'b0;
    while (!done) begin
      if (seg_kind == SEG_TONE) begin
        seg_kind = SEG_SPACE;
        seg_left = 17'(dot_len);
      end else if (gaps[PEND_LEAD]) begin
        gaps[PEND_LEAD] = 1'b0;
        seg_kind = SEG_LEAD;
        seg_left = 17'(lead_len);
      end else if (gaps[PEND_WORD]) begin
        gaps[PEND_WORD] = 1'b0;
        seg_kind = SEG_WORD;
        seg_left = word_gap;
      end else if (gaps[PEND_LETTER]) begin
        gaps[PEND_LETTER] = 1'b0;
        seg_kind = SEG_LETTER;
        seg_left = 17'(letter_gap);
      end else if (marks_cnt != 0) begin
        seg_kind = SEG_TONE;
        seg_left = marks_left[0] ? 17'(dash_len) : 17'(dot_len);
        marks_left = marks_left >> 1;
        marks_cnt = marks_cnt - 3'd1;
        tone_phase = '0;
      end else begin
        seg_kind = SEG_IDLE;
        seg_left = '0;
      end
      if (seg_left != 0 || seg_kind == SEG_IDLE) done = 1'b1;
    end
  endfunction

  function automatic keyed_out_t key_one_item(input logic [1:0] op, input logic [7:0] ch);
    keyed_out_t res;
    morse_t     m;
    res = '0;
    case (op)
      OP_START: clear_message();
      OP_CHAR: begin
        if (seg_kind == SEG_IDLE) begin
          res.accepted = 1'b1;
          if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13)) begin
            in_word = 1'b0;
          end else begin
            m = morse_of(ch);
            gaps = '0;
            if (lead_armed) gaps[PEND_LEAD] = 1'b1;
            lead_armed = 1'b0;
            if (in_word) gaps[PEND_LETTER] = 1'b1;
            else if (word_seen) gaps[PEND_WORD] = 1'b1;
            in_word = 1'b1;
            word_seen = 1'b1;
            marks_left = m.marks;
            marks_cnt = m.count;
            advance_segment();
          end
        end
      end
      OP_TICK: begin
        if (seg_kind != SEG_IDLE) begin
          if (seg_kind == SEG_TONE) begin
            res.sample = sine_of(tone_phase);
            res.tone_on = 1'b1;
            tone_phase = tone_phase + 16'(phase_step);
          end
          seg_left = seg_left - 17'd1;
          if (seg_left == 0) advance_segment();
        end
      end
      default: ;
    endcase
    res.busy = (seg_kind != SEG_IDLE);
    return res;
  endfunction

  task report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    keyed_out_t want;
    keyed_out_t seen;
    if (!rst_n) begin
      dot_len    = 14'd960;
      dash_len   = 16'd2880;
      letter_gap = 15'd1920;
      word_gap   = 17'd5760;
      lead_len   = 16'd2880;
      phase_step = 15'd6144;
      clear_message();
      awaited_out.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DOT_LEN:    dot_len    = cfg_wdata[13:0];
          CFG_DASH_LEN:   dash_len   = cfg_wdata[15:0];
          CFG_LETTER_GAP: letter_gap = cfg_wdata[14:0];
          CFG_WORD_GAP:   word_gap   = cfg_wdata[16:0];
          CFG_LEAD_LEN:   lead_len   = cfg_wdata[15:0];
          CFG_PHASE_STEP: phase_step = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[15:0], out_tdata[16], out_tdata[17], out_tdata[18]};
        if (awaited_out.size() == 0) begin
          report_mismatch("unexpected result item, queue depth", 1, 0);
        end else begin
          want = awaited_out.pop_front();
          checked++;
          if (want.tone_on) tone_samples++;
          if (want.accepted) chars_taken++;
          if (seen.sample != want.sample)
            report_mismatch("sample", longint'(seen.sample), longint'(want.sample));
          if (seen.tone_on != want.tone_on)
            report_mismatch("tone_on", seen.tone_on, want.tone_on);
          if (seen.busy != want.busy)
            report_mismatch("busy_res", seen.busy, want.busy);
          if (seen.accepted != want.accepted)
            report_mismatch("accepted", seen.accepted, want.accepted);
          if (out_tdata[23:19] != 5'd0)
            report_mismatch("pad bits", out_tdata[23:19], 0);
        end
      end
      if (in_tvalid && in_tready)
        awaited_out = {awaited_out, key_one_item(in_tuser, in_tdata)};
      pending <= awaited_out.size();
    end
  end

endmodule

// ===== dv/morse_keyer_tone_generator_unit_test.sv =====
// top of the morse keyer tone generator testbench: clock, reset, stimulus and verdict
// depends on mktg_pkg, the morse_keyer_tone_generator_unit rtl and mktg_tone_checker
module morse_keyer_tone_generator_unit_test;
  import mktg_pkg::*;

  // op value the block leaves unused
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] char_code
  logic [1:0]  in_tuser = 2'd0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [15:0] sample, [16] tone_on, [17] busy_res,
                                  // [18] accepted, [23:19] zero
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [16:0] cfg_wdata = 17'd0;

  int fail_count;
  int pending;
  int checked;
  int tone_samples;
  int chars_taken;

  bit idling = 1'b1;     // random bubbles on both sides
  int hold_asks = 0;     // long hold-offs asked of the receiver
  int hold_served = 0;   // long hold-offs the receiver has started
  int stall_left = 0;
  int settings = 0;

  always #1 clk = ~clk;

  morse_keyer_tone_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  mktg_tone_checker tone_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .tone_samples (tone_samples),
    .chars_taken  (chars_taken)
  );

  // receiver: short random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      stall_left = 60;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // offer one item, optionally after a short bubble, and return at the edge that takes it
  task send_item(input logic [1:0] op, input logic [7:0] ch);
    int gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every awaited result has come back
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task write_reg(input logic [2:0] addr, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= 17'(value);
    @(posedge clk);
  endtask

  // all six registers back to back, block must be idle
  task load_lengths(input int unsigned dot, input int unsigned dash,
                    input int unsigned letter, input int unsigned word,
                    input int unsigned lead, input int unsigned step);
    write_reg(CFG_DOT_LEN, dot);
    write_reg(CFG_DASH_LEN, dash);
    write_reg(CFG_LETTER_GAP, letter);
    write_reg(CFG_WORD_GAP, word);
    write_reg(CFG_LEAD_LEN, lead);
    write_reg(CFG_PHASE_STEP, step);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // mostly table characters, some whitespace, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int    r;
    int    w;
    string punct;
    punct = ".,?!/&:;_$@";
    r = $urandom_range(0, 99);
    if (r < 35) return 8'("A" + $urandom_range(0, 25));
    if (r < 55) return 8'("a" + $urandom_range(0, 25));
    if (r < 68) return 8'("0" + $urandom_range(0, 9));
    if (r < 80) return punct[$urandom_range(0, 10)];
    if (r < 90) begin
      w = $urandom_range(0, 5);
      return (w == 5) ? 8'd32 : 8'(9 + w);
    end
    return 8'($urandom);
  endfunction

  // message text: a character then a burst of ticks, with restarts and spare ops mixed in
  task run_text(input int n, input int tick_max, input int start_pct);
    int sent;
    int ticks;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < start_pct) begin
        send_item(OP_START, 8'($urandom));
        sent++;
      end else if (r < start_pct + 3) begin
        // ignored by the block, not counted
        send_item(OP_SPARE, 8'($urandom));
      end else begin
        send_item(OP_CHAR, pick_char());
        sent++;
        ticks = $urandom_range(0, tick_max);
        if (ticks > n - sent) ticks = n - sent;
        repeat (ticks) begin
          send_item(OP_TICK, 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  task random_small_lengths();
    load_lengths($urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(0, 4),
                 $urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 32767));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lead and letter gap zero so they get skipped, highest phase step
    load_lengths(1, 2, 0, 1, 0, 32767);
    send_item(OP_TICK, 8'h00);      // tick with nothing queued
    send_item(OP_SPARE, 8'hff);     // unused op while idle
    send_item(OP_CHAR, "e");        // lowercase folds, single dot
    send_item(OP_CHAR, "T");        // refused, still keying the e
    send_item(OP_TICK, 8'hff);
    send_item(OP_TICK, 8'h55);
    send_item(OP_CHAR, 8'hff);      // unrecognized, no elements, zero letter gap
    send_item(OP_CHAR, 8'h00);      // unrecognized again
    send_item(OP_CHAR, " ");        // ends the word
    send_item(OP_CHAR, "$");        // seven elements after a word gap
    send_item(OP_SPARE, 8'h00);     // unused op while busy
    repeat (4) send_item(OP_TICK, 8'haa);
    send_item(OP_START, 8'h00);     // drops the rest of the $
    send_item(OP_TICK, 8'h00);
    send_item(OP_CHAR, 8'd9);       // tab and carriage return are whitespace
    send_item(OP_CHAR, 8'd13);
    send_item(OP_CHAR, "@");        // lead armed again after the restart
    repeat (3) send_item(OP_TICK, 8'h0f);
    drain();

    // shortest lengths, zero gaps and zero phase step
    load_lengths(1, 1, 0, 0, 0, 0);
    run_text(100, 10, 4);
    drain();

    random_small_lengths();
    run_text(120, 40, 3);
    drain();

    // long receiver hold-off so the input side backs up
    random_small_lengths();
    hold_asks++;
    run_text(120, 40, 3);
    drain();

    random_small_lengths();
    run_text(120, 40, 3);
    drain();

    // longest tones and fastest phase step, restarts keep the run short
    load_lengths(16383, 65535, 0, 0, 0, 32767);
    run_text(80, 50, 12);
    drain();

    // longest lead silence
    load_lengths(1, 1, 1, 1, 65535, 1);
    run_text(60, 20, 15);
    drain();

    // longest letter and word gaps
    load_lengths(1, 1, 32767, 131071, 0, 16384);
    run_text(80, 12, 15);
    drain();

    // back to back items on both sides to the end
    idling = 1'b0;
    random_small_lengths();
    run_text(150, 40, 3);
    drain();
    repeat (8) @(posedge clk);

    $display("checked %0d result items over %0d register settings", checked, settings);
    $display("%0d tone samples, %0d characters taken", tone_samples, chars_taken);
    if (fail_count == 0 && pending == 0) begin
      $display("morse_keyer_tone_generator_unit_test passed");
    end else begin
      $display("morse_keyer_tone_generator_unit_test failed");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #400000;
    $display("morse_keyer_tone_generator_unit_test failed");
    $finish;
  end

endmodule
